>>> design/ars_pkg.sv
`default_nettype none

package ars_pkg;

  localparam int unsigned NUM_CHANNELS = 6;
  localparam int unsigned COUNT_WIDTH  = 8;

  localparam int unsigned CH_W      = 3;
  localparam int unsigned MASK_W    = 6;
  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned RCOUNT_W  = 8;
  localparam int unsigned MUX_W     = 4;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [VALUE_W-1:0]  VALUE_UNSAMPLED = 16'hFFFF;
  localparam logic [MASK_W-1:0]   MASK_RESET      = 6'h3F;
  localparam logic [MUX_W-1:0]    MUX_NONE        = 4'd0;

  typedef struct packed {
    logic            start;
    logic [CH_W-1:0] channel;
    logic [MUX_W-1:0] mux_code;
  } pick_t;

  typedef struct packed {
    logic                we;
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
  } store_t;

  // analog mux select per channel
  function automatic logic [MUX_W-1:0] mux_code_of(input logic [CH_W-1:0] ch);
    logic [MUX_W-1:0] code;
    unique case (ch)
      3'd0:    code = 4'd9;
      3'd1:    code = 4'd8;
      3'd2:    code = 4'd7;
      3'd3:    code = 4'd4;
      3'd4:    code = 4'd5;
      3'd5:    code = 4'd6;
      default: code = MUX_NONE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

>>> design/ars_chan_pick.sv
`default_nettype none

module ars_chan_pick
  import ars_pkg::*;
(
  input  wire logic [CH_W-1:0]   cur_channel_i,
  input  wire logic [MASK_W-1:0] enable_mask_i,
  output pick_t                  pick_o
);

  logic [CH_W:0]   cand;
  logic            found;
  logic [CH_W-1:0] pick_ch;

  // walk from farthest to nearest so the nearest enabled channel wins
  always_comb begin
    found   = 1'b0;
    pick_ch = '0;
    cand    = '0;
    for (int unsigned k = NUM_CHANNELS; k >= 1; k--) begin
      cand = {1'b0, cur_channel_i} + (CH_W+1)'(k);
      if (cand >= (CH_W+1)'(NUM_CHANNELS)) begin
        cand = cand - (CH_W+1)'(NUM_CHANNELS);
      end
      for (int unsigned j = 0; j < NUM_CHANNELS; j++) begin
        if (cand == (CH_W+1)'(j) && enable_mask_i[j]) begin
          found   = 1'b1;
          pick_ch = CH_W'(j);
        end
      end
    end
  end

  always_comb begin
    pick_o.start    = found;
    pick_o.channel  = found ? pick_ch : '0;
    pick_o.mux_code = found ? mux_code_of(pick_ch) : MUX_NONE;
  end

endmodule

`default_nettype wire

>>> design/ars_chan_bank.sv
`default_nettype none

module ars_chan_bank
  import ars_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire store_t              store_i,
  input  wire logic [CH_W-1:0]     read_channel_i,
  output logic [VALUE_W-1:0]       read_value_o,
  output logic [RCOUNT_W-1:0]      read_count_o
);

  logic [VALUE_W-1:0]     values_q [NUM_CHANNELS];
  logic [VALUE_W-1:0]     values_d [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0] counts_q [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0] counts_d [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0] rd_count;
  logic [31:0]            rd_count_ext;

  always_comb begin
    for (int unsigned i = 0; i < NUM_CHANNELS; i++) begin
      values_d[i] = values_q[i];
      counts_d[i] = counts_q[i];
      if (store_i.we && store_i.channel == CH_W'(i)) begin
        values_d[i] = VALUE_W'(store_i.sample);
        counts_d[i] = counts_q[i] + COUNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < NUM_CHANNELS; i++) begin
        values_q[i] <= VALUE_UNSAMPLED;
        counts_q[i] <= '0;
      end
    end else begin
      for (int unsigned i = 0; i < NUM_CHANNELS; i++) begin
        values_q[i] <= values_d[i];
        counts_q[i] <= counts_d[i];
      end
    end
  end

  // report the state after this item's store
  always_comb begin
    read_value_o = VALUE_UNSAMPLED;
    rd_count     = '0;
    for (int unsigned i = 0; i < NUM_CHANNELS; i++) begin
      if (read_channel_i == CH_W'(i)) begin
        read_value_o = values_d[i];
        rd_count     = counts_d[i];
      end
    end
    rd_count_ext = 32'(rd_count);
    read_count_o = rd_count_ext[RCOUNT_W-1:0];
  end

endmodule

`default_nettype wire

>>> design/adc_round_robin_scanner.sv
// Round-robin scan controller for one converter shared by six analog channels.
// Slave stream: one service tick per item; tdata carries the converter busy
// flag, its latest 10-bit result and the channel to report. Master stream:
// one result per tick with the store flag and channel, the start flag,
// channel and analog mux code, and the stored value and count of the
// reported channel (as they stand after this tick).
// Config channel: writes the 6-bit channel enable mask; always ready. Write
// it only while no tick is in flight.
// Timing: an accepted tick passes through the input register and then the
// result register to the master side. Throughput: one tick per cycle while
// the receiver does not stall; the next-channel pick and the store run
// combinationally between the input register and the result register.
// Reset: mask = all channels, current channel 0, nothing pending, every
// stored value 0xFFFF, every count 0; both streams empty.
// Receiver stall: the result register holds, the input register still
// takes one more tick, then s_axis_tready drops until the result is taken.
`default_nettype none

module adc_round_robin_scanner
  import ars_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [0] converter_busy, [10:1] sample, [13:11] read_channel, [15:14] zero
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [0] stored, [3:1] stored_channel, [4] start_res, [7:5] start_channel,
  // [11:8] mux_code, [27:12] read_value, [35:28] read_count, [39:36] zero
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [MASK_W-1:0]     cfg_data_i
);

  logic                 in_valid_q;
  logic                 in_busy_q;
  logic [SAMPLE_W-1:0]  in_sample_q;
  logic [CH_W-1:0]      in_rd_q;
  logic                 out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_DATA_W-1:0] out_data_d;

  logic [MASK_W-1:0]    mask_q;
  logic [CH_W-1:0]      cur_q, cur_d;
  logic                 pending_q, pending_d;

  logic                 advance;
  logic                 fire;
  logic                 active;
  pick_t                pick;
  store_t               store;
  logic [VALUE_W-1:0]   rd_value;
  logic [RCOUNT_W-1:0]  rd_count;

  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign active        = fire && !in_busy_q;
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  ars_chan_pick u_pick (
    .cur_channel_i (cur_q),
    .enable_mask_i (mask_q),
    .pick_o        (pick)
  );

  always_comb begin
    store.we      = active && pending_q && (cur_q < CH_W'(NUM_CHANNELS));
    store.channel = cur_q;
    store.sample  = in_sample_q;
  end

  ars_chan_bank u_bank (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .store_i        (store),
    .read_channel_i (in_rd_q),
    .read_value_o   (rd_value),
    .read_count_o   (rd_count)
  );

  always_comb begin
    cur_d     = cur_q;
    pending_d = pending_q;
    if (active) begin
      pending_d = pick.start;
      if (pick.start) begin
        cur_d = pick.channel;
      end
    end
  end

  always_comb begin
    out_data_d        = '0;
    out_data_d[0]     = store.we;
    out_data_d[3:1]   = store.we ? cur_q : '0;
    out_data_d[4]     = active && pick.start;
    out_data_d[7:5]   = active ? pick.channel : '0;
    out_data_d[11:8]  = active ? pick.mux_code : MUX_NONE;
    out_data_d[27:12] = rd_value;
    out_data_d[35:28] = rd_count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mask_q      <= MASK_RESET;
      cur_q       <= '0;
      pending_q   <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (cfg_valid_i) begin
        mask_q <= cfg_data_i;
      end
      cur_q     <= cur_d;
      pending_q <= pending_d;
    end
  end

  // payload registers: load on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_busy_q   <= s_axis_tdata[0];
      in_sample_q <= s_axis_tdata[10:1];
      in_rd_q     <= s_axis_tdata[13:11];
    end
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire
